### src/gpg_pkg.sv
package gpg_pkg;

    // Colour and channel widths
    localparam int CH_W    = 8;
    localparam int NCH     = 3;
    localparam int COLOR_W = CH_W * NCH;

    // Result layout: four table entries per transfer
    localparam int LANES = 4;
    localparam int LW    = $clog2(LANES);
    localparam int IDX_W = 8;

    // Divider operand widths
    localparam int NUM_W = 17;
    localparam int DEN_W = 9;
    localparam int QUO_W = 8;

    typedef logic [COLOR_W-1:0] color_t;
    typedef logic [NUM_W-1:0]   num_t;
    typedef logic [DEN_W-1:0]   den_t;
    typedef logic [QUO_W-1:0]   quot_t;

endpackage

### src/gpg_ram.sv
module gpg_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

### src/gpg_div.sv
module gpg_div
    import gpg_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    input  num_t  num [NCH],
    input  den_t  den,
    output logic  valid,
    output quot_t quot [NCH]
);

    localparam int SW = $clog2(QUO_W);

    logic          busy_reg;
    logic          valid_reg;
    logic [SW-1:0] step_reg;
    num_t          rem_reg [NCH];
    den_t          den_reg;
    quot_t         quot_reg [NCH];
    num_t          shifted;

    // Divisor aligned to the quotient bit under trial
    assign shifted = NUM_W'(den_reg) << step_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            valid_reg <= 1'b0;
            step_reg  <= '0;
        end
        else
        begin
            valid_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= SW'(QUO_W - 1);
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg - 1'b1;
                if (step_reg == '0)
                begin
                    busy_reg  <= 1'b0;
                    valid_reg <= 1'b1;
                end
            end
        end
    end

    // Restoring division, one quotient bit per cycle in every channel
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            den_reg <= den;
            for (int l = 0; l < NCH; l++)
            begin
                rem_reg[l]  <= num[l];
                quot_reg[l] <= '0;
            end
        end
        else if (busy_reg)
        begin
            for (int l = 0; l < NCH; l++)
            begin
                if (rem_reg[l] >= shifted)
                begin
                    rem_reg[l]            <= rem_reg[l] - shifted;
                    quot_reg[l][step_reg] <= 1'b1;
                end
            end
        end
    end

    assign valid = valid_reg;
    assign quot  = quot_reg;

endmodule

### src/gradient_palette_generator.sv
// Gradient palette generator.
//
// Slave channel: one colour stop per transfer (s_tdata), s_tlast marks the
// final stop of a list. Stops are kept in a small synchronous stop memory.
// Master channel: after the final stop the block walks the table index by
// index and sends four entries per transfer, lowest index first; m_tlast
// marks the last transfer of the table. A list of fewer than two stops or
// more than MAX_STOPS stops gives one transfer with m_tuser set and zeros.
// Stops are taken one per cycle while the block idles. Each interpolated
// table entry takes one pass of the 8-step shared divider; each segment
// change costs two stop memory reads plus, but for the last segment, one
// divider pass for its end index. No stop is taken while the table is
// generated.
// Reset clears the stop count, the overflow flag and the output valid; the
// stop memory holds no reset value and needs no clearing pass.
// A stalled receiver (m_tready low) holds the output register and the walk
// waits at the next transfer; nothing is dropped.
module gradient_palette_generator
    import gpg_pkg::*;
#(
    parameter int TABLE_SIZE = 256,
    parameter int MAX_STOPS  = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [23:0]  s_tdata,   // stop_red, stop_green, stop_blue
    input  logic         s_tlast,   // final_stop
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [103:0] m_tdata,   // base_index, entry_a, entry_b, entry_c, entry_d
    output logic         m_tlast,   // table_done
    output logic         m_tuser    // stop_error
);

    localparam int AW = $clog2(MAX_STOPS);
    localparam int CW = $clog2(MAX_STOPS + 1);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SIZE - 1);
    localparam logic [IDX_W-1:0] PAD_LAST =
        IDX_W'(((TABLE_SIZE + LANES - 1) / LANES) * LANES - 1);
    localparam num_t             TWO_GAPS = NUM_W'(2 * (TABLE_SIZE - 1));

    typedef enum logic [10:0] {
        S_IDLE  = 11'b000_0000_0001,
        S_ERR   = 11'b000_0000_0010,
        S_RDA   = 11'b000_0000_0100,
        S_RDB   = 11'b000_0000_1000,
        S_EDGE  = 11'b000_0001_0000,
        S_EWAIT = 11'b000_0010_0000,
        S_CHECK = 11'b000_0100_0000,
        S_MUL   = 11'b000_1000_0000,
        S_BWAIT = 11'b001_0000_0000,
        S_NEXT  = 11'b010_0000_0000,
        S_EMIT  = 11'b100_0000_0000
    } state_t;

    state_t            state_reg;
    state_t            state_next;
    logic [CW-1:0]     count_reg;
    logic              ovf_reg;
    logic              out_valid_reg;

    logic [CW-1:0]     segs_reg;
    logic [CW-1:0]     b_reg;
    logic [IDX_W-1:0]  lo_reg;
    logic [IDX_W-1:0]  hi_reg;
    logic [IDX_W-1:0]  x_reg;
    logic [IDX_W-1:0]  w_reg;
    logic [IDX_W-1:0]  i_reg;
    logic [IDX_W-1:0]  wmi_reg;
    color_t            ca_reg;
    color_t            cb_reg;
    color_t            lane_reg [LANES];

    logic [IDX_W-1:0]  out_base_reg;
    color_t            out_lane_reg [LANES];
    logic              out_last_reg;
    logic              out_err_reg;

    logic              in_acc;
    logic              room;
    logic [CW-1:0]     k_new;
    logic              list_err;
    logic              out_free;
    logic              last_seg;
    logic              need_adv;

    logic              ram_wr_en;
    logic [AW-1:0]     ram_rd_addr;
    color_t            ram_wr_data;
    color_t            ram_rd_data;

    logic              div_start;
    num_t              div_num [NCH];
    den_t              div_den;
    logic              div_valid;
    quot_t             div_quot [NCH];
    num_t              edge_num;
    num_t              blend_num [NCH];
    logic [15:0]       prod_a [NCH];
    logic [15:0]       prod_b [NCH];

    // Stop intake
    assign s_tready = (state_reg == S_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign room     = (count_reg < CW'(MAX_STOPS));
    assign k_new    = room ? count_reg + 1'b1 : count_reg;
    assign list_err = (k_new < CW'(2)) || ovf_reg || !room;
    assign out_free = !out_valid_reg || m_tready;

    assign last_seg = (b_reg == segs_reg);
    assign need_adv = !last_seg && (hi_reg <= x_reg);

    // Stored colour packed red, green, blue from the top byte down
    assign ram_wr_en   = in_acc && room;
    assign ram_wr_data = {s_tdata[7:0], s_tdata[15:8], s_tdata[23:16]};
    assign ram_rd_addr = (state_reg == S_RDB && !last_seg) ? AW'(b_reg + 1'b1)
                                                           : AW'(b_reg);

    gpg_ram #(
        .WIDTH (COLOR_W),
        .DEPTH (MAX_STOPS)
    ) u_stop_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Segment end: round((TABLE_SIZE-1)*(b+1)/segs), halves up
    assign edge_num = TWO_GAPS * NUM_W'(b_reg + 1'b1) + NUM_W'(segs_reg);

    // Blend numerator per channel: 2*(ca*(w-i) + cb*i) + w
    always_comb
    begin
        for (int c = 0; c < NCH; c++)
        begin
            prod_a[c]    = ca_reg[c*CH_W +: CH_W] * wmi_reg;
            prod_b[c]    = cb_reg[c*CH_W +: CH_W] * i_reg;
            blend_num[c] = ((NUM_W'(prod_a[c]) + NUM_W'(prod_b[c])) << 1)
                           + NUM_W'(w_reg);
        end
    end

    assign div_start = (state_reg == S_EDGE && !last_seg) || (state_reg == S_MUL);

    always_comb
    begin
        for (int c = 0; c < NCH; c++)
        begin
            div_num[c] = (state_reg == S_EDGE) ? edge_num : blend_num[c];
        end
        div_den = (state_reg == S_EDGE) ? DEN_W'(segs_reg) << 1 : DEN_W'(w_reg) << 1;
    end

    gpg_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .valid (div_valid),
        .quot  (div_quot)
    );

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_acc && s_tlast)
                begin
                    state_next = list_err ? S_ERR : S_RDA;
                end
            end
            S_ERR:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_RDA:   state_next = S_RDB;
            S_RDB:   state_next = S_EDGE;
            S_EDGE:  state_next = last_seg ? S_CHECK : S_EWAIT;
            S_EWAIT:
            begin
                if (div_valid)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (x_reg > LAST_IDX)
                begin
                    state_next = S_NEXT;
                end
                else if (need_adv)
                begin
                    state_next = S_RDA;
                end
                else if (last_seg)
                begin
                    state_next = S_NEXT;
                end
                else
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:   state_next = S_BWAIT;
            S_BWAIT:
            begin
                if (div_valid)
                begin
                    state_next = S_NEXT;
                end
            end
            S_NEXT:
            begin
                state_next = (x_reg[LW-1:0] == LW'(LANES - 1)) ? S_EMIT : S_CHECK;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    state_next = (x_reg == PAD_LAST) ? S_IDLE : S_CHECK;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (in_acc)
            begin
                if (s_tlast)
                begin
                    count_reg <= '0;
                    ovf_reg   <= 1'b0;
                end
                else if (room)
                begin
                    count_reg <= count_reg + 1'b1;
                end
                else
                begin
                    ovf_reg <= 1'b1;
                end
            end

            if ((state_reg == S_ERR || state_reg == S_EMIT) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Walk datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                segs_reg <= k_new - 1'b1;
                b_reg    <= '0;
                lo_reg   <= '0;
                x_reg    <= '0;
            end
            S_RDB:
            begin
                ca_reg <= ram_rd_data;
            end
            S_EDGE:
            begin
                cb_reg <= ram_rd_data;
            end
            S_EWAIT:
            begin
                if (div_valid)
                begin
                    hi_reg <= div_quot[0];
                end
            end
            S_CHECK:
            begin
                if (x_reg > LAST_IDX)
                begin
                    // Pad past the end of the table
                    lane_reg[x_reg[LW-1:0]] <= '0;
                end
                else if (need_adv)
                begin
                    lo_reg <= hi_reg;
                    b_reg  <= b_reg + 1'b1;
                end
                else if (last_seg)
                begin
                    // Final entry is the last stop itself
                    lane_reg[x_reg[LW-1:0]] <= ca_reg;
                end
                else
                begin
                    w_reg   <= hi_reg - lo_reg;
                    i_reg   <= x_reg - lo_reg;
                    wmi_reg <= hi_reg - x_reg;
                end
            end
            S_BWAIT:
            begin
                if (div_valid)
                begin
                    lane_reg[x_reg[LW-1:0]] <= {div_quot[2], div_quot[1], div_quot[0]};
                end
            end
            S_NEXT:
            begin
                if (x_reg[LW-1:0] != LW'(LANES - 1))
                begin
                    x_reg <= x_reg + 1'b1;
                end
            end
            S_EMIT:
            begin
                if (out_free && x_reg != PAD_LAST)
                begin
                    x_reg <= x_reg + 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Output register
    always_ff @(posedge clk)
    begin
        if (state_reg == S_ERR && out_free)
        begin
            out_base_reg <= '0;
            out_last_reg <= 1'b1;
            out_err_reg  <= 1'b1;
            for (int l = 0; l < LANES; l++)
            begin
                out_lane_reg[l] <= '0;
            end
        end
        else if (state_reg == S_EMIT && out_free)
        begin
            out_base_reg <= {x_reg[IDX_W-1:LW], LW'(0)};
            out_last_reg <= (x_reg == PAD_LAST);
            out_err_reg  <= 1'b0;
            for (int l = 0; l < LANES; l++)
            begin
                out_lane_reg[l] <= lane_reg[l];
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_lane_reg[3], out_lane_reg[2], out_lane_reg[1],
                       out_lane_reg[0], out_base_reg};
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_err_reg;

endmodule
